// ----- hdl/brfa_pkg.sv -----
// Shared types, widths and constants of the boundary repulsion force accumulator.
// No dependencies.
package brfa_pkg;

	localparam int unsigned IDX_W   = 10;
	localparam int unsigned POS_W   = 48;
	localparam int unsigned MAG_W   = 40;
	localparam int unsigned ACC_W   = 48;
	localparam int unsigned CUT_W   = 40;
	localparam int unsigned STR_W   = 24;
	localparam int unsigned TYPE_W  = 8;
	localparam int unsigned CFG_W   = 48;
	localparam int unsigned CFGI_W  = 2;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned MAX_PARTICLES_DEF = 1024;
	localparam int unsigned DIMENSIONS_DEF    = 3;

	localparam logic [CFGI_W-1:0] REG_GRAVITY_ENABLE  = 2'd0;
	localparam logic [CFGI_W-1:0] REG_GRAVITY_ACCEL   = 2'd1;
	localparam logic [CFGI_W-1:0] REG_CUTOFF_DISTANCE = 2'd2;
	localparam logic [CFGI_W-1:0] REG_FORCE_STRENGTH  = 2'd3;

	localparam logic [ACC_W-1:0] GRAVITY_ACCEL_RST   = 48'hFFFF_F633_3333;
	localparam logic [CUT_W-1:0] CUTOFF_DISTANCE_RST = 40'd13743895;
	localparam logic [STR_W-1:0] FORCE_STRENGTH_RST  = 24'd167772;

	typedef struct packed {
		logic                       op;
		logic                       oor;
		logic [IDX_W-1:0]           idx;
		logic [2:0]                 neg;
		logic [2:0][MAG_W-1:0]      mag;
	} item_t;

	typedef struct packed {
		logic [ACC_W-1:0] val;
		logic             sat;
	} sat_t;

	function automatic sat_t sat_add(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
		logic [ACC_W:0] s;
		sat_t r;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		r.sat = s[ACC_W] ^ s[ACC_W-1];
		if (r.sat) begin
			r.val = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			r.val = s[ACC_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- hdl/brfa_front.sv -----
// Front end: takes request beats, drops pairs that cannot interact and
// forms the work entry. Depends on brfa_pkg.
module brfa_front #(
	parameter int unsigned MAX_PARTICLES = brfa_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned DIMENSIONS    = brfa_pkg::DIMENSIONS_DEF
) (
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            op,
	input  logic [brfa_pkg::IDX_W-1:0]      particle_index,
	input  logic [brfa_pkg::TYPE_W-1:0]     type_first,
	input  logic [brfa_pkg::TYPE_W-1:0]     type_second,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_x,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_y,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_z,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_x,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_y,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_z,
	input  logic                            q_full,
	output logic                            q_push,
	output brfa_pkg::item_t                 q_item
);

	logic [2:0][brfa_pkg::POS_W-1:0] pa;
	logic [2:0][brfa_pkg::POS_W-1:0] pb;
	logic [2:0]                      far;
	logic                            types_ok;
	logic                            keep;

	assign pa = {first_pos_z, first_pos_y, first_pos_x};
	assign pb = {second_pos_z, second_pos_y, second_pos_x};

	always_comb begin
		logic [brfa_pkg::POS_W:0] d;
		logic [brfa_pkg::POS_W:0] m;
		q_item.op  = op;
		q_item.idx = particle_index;
		q_item.oor = {22'b0, particle_index} >= 32'(MAX_PARTICLES);
		for (int k = 0; k < 3; k++) begin
			d = {pa[k][brfa_pkg::POS_W-1], pa[k]} - {pb[k][brfa_pkg::POS_W-1], pb[k]};
			m = d[brfa_pkg::POS_W] ? (~d + 1'b1) : d;
			if (k >= DIMENSIONS) begin
				q_item.neg[k] = 1'b0;
				q_item.mag[k] = '0;
				far[k]        = 1'b0;
			end else begin
				q_item.neg[k] = d[brfa_pkg::POS_W];
				q_item.mag[k] = m[brfa_pkg::MAG_W-1:0];
				far[k]        = |m[brfa_pkg::POS_W:brfa_pkg::MAG_W];
			end
		end
	end

	assign types_ok = !type_first[brfa_pkg::TYPE_W-1] && (|type_first)
		&& type_second[brfa_pkg::TYPE_W-1];
	assign keep      = op || (!q_item.oor && types_ok && !(|far));
	assign req_stall = q_full;
	assign q_push    = req_valid && !q_full && keep;

endmodule

// ----- hdl/brfa_queue.sv -----
// Short queue between front end and back end.
// Depends on brfa_pkg.
module brfa_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  brfa_pkg::item_t push_item,
	input  logic            pop,
	output logic            full,
	output logic            not_empty,
	output brfa_pkg::item_t head
);

	localparam int unsigned PW = $clog2(brfa_pkg::QUEUE_DEPTH);

	brfa_pkg::item_t       slot_q [brfa_pkg::QUEUE_DEPTH];
	logic [PW-1:0]         wp_q;
	logic [PW-1:0]         rp_q;
	logic [PW:0]           cnt_q;

	assign full      = cnt_q == (PW+1)'(brfa_pkg::QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_item;
	end

endmodule

// ----- hdl/brfa_mul.sv -----
// Multi-cycle 64x64 unsigned multiplier from one 32x32 partial product a cycle.
// No dependencies.
module brfa_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] p
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [2:0]   cnt_q;
	logic         run_q;
	logic         done_q;
	logic         pv_s1;
	logic [63:0]  part_s1;
	logic [1:0]   ph_s1;
	logic [127:0] acc_q;
	logic [31:0]  ah;
	logic [31:0]  bh;
	logic [1:0]   sh;

	assign ah   = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh   = cnt_q[0] ? b_q[63:32] : b_q[31:0];
	assign sh   = {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
	assign done = done_q;
	assign p    = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			pv_s1  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
				pv_s1 <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				pv_s1 <= !cnt_q[2];
				if (cnt_q[2]) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end else begin
				pv_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else begin
			part_s1 <= ah * bh;
			ph_s1   <= sh;
			if (pv_s1) acc_q <= acc_q + ({64'b0, part_s1} << {ph_s1, 5'b0});
		end
	end

endmodule

// ----- hdl/brfa_div.sv -----
// Restoring divider, one quotient bit a cycle, 80-bit divisor.
// No dependencies.
module brfa_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [79:0] rem0,
	input  logic [46:0] low,
	input  logic [5:0]  steps,
	input  logic [79:0] den,
	output logic        done,
	output logic [46:0] quo
);

	logic [79:0] rem_q;
	logic [46:0] low_q;
	logic [79:0] den_q;
	logic [46:0] quo_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [80:0] t;
	logic [80:0] diff;
	logic        ge;

	assign t    = {rem_q, low_q[46]};
	assign diff = t - {1'b0, den_q};
	assign ge   = t >= {1'b0, den_q};
	assign done = done_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= steps;
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 6'd1) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem0;
			low_q <= low;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? diff[79:0] : t[79:0];
			low_q <= {low_q[45:0], 1'b0};
			quo_q <= {quo_q[45:0], ge};
		end
	end

endmodule

// ----- hdl/brfa_back.sv -----
// Back end: sequences the force math over the shared multiplier and divider,
// owns the acceleration stores and the result register. Depends on brfa_pkg,
// brfa_mul and brfa_div.
module brfa_back #(
	parameter int unsigned MAX_PARTICLES = brfa_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned DIMENSIONS    = brfa_pkg::DIMENSIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_not_empty,
	input  brfa_pkg::item_t                 q_head,
	output logic                            q_pop,
	input  logic                            gravity_enable,
	input  logic [brfa_pkg::ACC_W-1:0]      gravity_accel,
	input  logic [brfa_pkg::CUT_W-1:0]      cutoff_distance,
	input  logic [brfa_pkg::STR_W-1:0]      force_strength,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [brfa_pkg::IDX_W-1:0]      read_index,
	output logic [brfa_pkg::ACC_W-1:0]      accel_x,
	output logic [brfa_pkg::ACC_W-1:0]      accel_y,
	output logic [brfa_pkg::ACC_W-1:0]      accel_z,
	output logic                            saturated
);

	localparam int unsigned AW = $clog2(MAX_PARTICLES);
	localparam int unsigned AWD = brfa_pkg::ACC_W;

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] ST_RA   = 5'd2;
	localparam logic [4:0] ST_RB   = 5'd3;
	localparam logic [4:0] ST_R2   = 5'd4;
	localparam logic [4:0] ST_C2   = 5'd5;
	localparam logic [4:0] ST_QCHK = 5'd6;
	localparam logic [4:0] ST_QDIV = 5'd7;
	localparam logic [4:0] ST_Q2   = 5'd8;
	localparam logic [4:0] ST_Q4   = 5'd9;
	localparam logic [4:0] ST_Q6   = 5'd10;
	localparam logic [4:0] ST_AX   = 5'd11;
	localparam logic [4:0] ST_FM   = 5'd12;
	localparam logic [4:0] ST_FG   = 5'd13;
	localparam logic [4:0] ST_MCHK = 5'd14;
	localparam logic [4:0] ST_MDIV = 5'd15;
	localparam logic [4:0] ST_ACC  = 5'd16;
	localparam logic [4:0] ST_WB   = 5'd17;

	localparam logic [37:0] Q_CAP = {38{1'b1}};
	localparam logic [46:0] M_CAP = {47{1'b1}};

	logic [AWD-1:0] mem_x [MAX_PARTICLES];
	logic [AWD-1:0] mem_y [MAX_PARTICLES];
	logic [AWD-1:0] mem_z [MAX_PARTICLES];
	logic           mem_f [MAX_PARTICLES];

	logic [4:0]          st_q;
	logic [AW-1:0]       clr_q;
	brfa_pkg::item_t     it_q;
	logic [AW-1:0]       addr_q;
	logic [AWD-1:0]      rd_x_q;
	logic [AWD-1:0]      rd_y_q;
	logic [AWD-1:0]      rd_z_q;
	logic                rd_f_q;
	logic [2:0][AWD-1:0] acc_q;
	logic                fl_q;
	logic                clip_q;
	logic                gs_q;
	logic [1:0]          ax_q;
	logic [81:0]         r2_q;
	logic [79:0]         c2_q;
	logic [37:0]         q_q;
	logic [63:0]         q2_q;
	logic [63:0]         g_q;
	logic [63:0]         fm_q;
	logic [127:0]        num_q;
	logic [46:0]         m_q;
	logic                mbusy_q;
	logic                dbusy_q;

	logic                rsp_valid_q;
	logic [brfa_pkg::IDX_W-1:0] rsp_idx_q;
	logic [AWD-1:0]      rsp_x_q;
	logic [AWD-1:0]      rsp_y_q;
	logic [AWD-1:0]      rsp_z_q;
	logic                rsp_f_q;

	logic                mul_state;
	logic                mul_start;
	logic [63:0]         mul_a;
	logic [63:0]         mul_b;
	logic                mul_done;
	logic [127:0]        mul_p;
	logic                div_state;
	logic                div_start;
	logic [79:0]         div_rem0;
	logic [46:0]         div_low;
	logic [5:0]          div_steps;
	logic                div_done;
	logic [46:0]         div_quo;

	logic                mq_sat;
	logic [63:0]         mq_val;
	logic                out_free;
	logic                rsp_load;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [AWD-1:0]      wr_x;
	logic [AWD-1:0]      wr_y;
	logic [AWD-1:0]      wr_z;
	logic                wr_f;
	brfa_pkg::sat_t      grav;
	brfa_pkg::sat_t      accs;
	logic [AWD-1:0]      contrib;
	logic [AWD-1:0]      last_rd;

	assign mq_sat = |mul_p[127:96];
	assign mq_val = mq_sat ? '1 : mul_p[95:32];

	assign mul_state = (st_q == ST_R2) || (st_q == ST_C2) || (st_q == ST_Q2)
		|| (st_q == ST_Q4) || (st_q == ST_Q6) || (st_q == ST_FM) || (st_q == ST_FG);
	assign mul_start = mul_state && !mbusy_q;
	assign div_state = (st_q == ST_QDIV) || (st_q == ST_MDIV);
	assign div_start = div_state && !dbusy_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			ST_R2: begin
				mul_a = {24'b0, it_q.mag[ax_q]};
				mul_b = {24'b0, it_q.mag[ax_q]};
			end
			ST_C2: begin
				mul_a = {24'b0, cutoff_distance};
				mul_b = {24'b0, cutoff_distance};
			end
			ST_Q2: begin
				mul_a = {26'b0, q_q};
				mul_b = {26'b0, q_q};
			end
			ST_Q4: begin
				mul_a = q2_q;
				mul_b = q2_q;
			end
			ST_Q6: begin
				mul_a = g_q;
				mul_b = q2_q;
			end
			ST_FM: begin
				mul_a = {24'b0, it_q.mag[ax_q]};
				mul_b = {40'b0, force_strength};
			end
			ST_FG: begin
				mul_a = fm_q;
				mul_b = g_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		if (st_q == ST_QDIV) begin
			div_rem0  = {7'b0, c2_q[79:7]};
			div_low   = {c2_q[6:0], 40'b0};
			div_steps = 6'd39;
		end else begin
			div_rem0  = num_q[118:39];
			div_low   = {num_q[38:0], 8'b0};
			div_steps = 6'd47;
		end
	end

	brfa_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	brfa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.rem0   (div_rem0),
		.low    (div_low),
		.steps  (div_steps),
		.den    (r2_q[79:0]),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign last_rd  = (DIMENSIONS == 3) ? rd_z_q : rd_y_q;
	assign grav     = brfa_pkg::sat_add(last_rd, gravity_accel);
	assign contrib  = it_q.neg[ax_q] ? (~{1'b0, m_q} + 1'b1) : {1'b0, m_q};
	assign accs     = brfa_pkg::sat_add(acc_q[ax_q], contrib);
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_load = (st_q == ST_RB) && it_q.op && out_free;
	assign q_pop    = (st_q == ST_IDLE) && q_not_empty;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_x    = '0;
		wr_y    = '0;
		wr_z    = '0;
		wr_f    = 1'b0;
		if (st_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
		end else if (rsp_load) begin
			wr_en = !it_q.oor;
		end else if (st_q == ST_WB) begin
			wr_en = 1'b1;
			wr_x  = acc_q[0];
			wr_y  = acc_q[1];
			wr_z  = acc_q[2];
			wr_f  = fl_q || clip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_x[wr_addr] <= wr_x;
			mem_y[wr_addr] <= wr_y;
			mem_z[wr_addr] <= wr_z;
			mem_f[wr_addr] <= wr_f;
		end
		rd_x_q <= mem_x[addr_q];
		rd_y_q <= mem_y[addr_q];
		rd_z_q <= mem_z[addr_q];
		rd_f_q <= mem_f[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLR;
			clr_q       <= '0;
			mbusy_q     <= 1'b0;
			dbusy_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (mul_start) mbusy_q <= 1'b1;
			else if (mul_done) mbusy_q <= 1'b0;
			if (div_start) dbusy_q <= 1'b1;
			else if (div_done) dbusy_q <= 1'b0;
			if (rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(MAX_PARTICLES - 1)) st_q <= ST_IDLE;
				end
				ST_IDLE: if (q_not_empty) st_q <= ST_RA;
				ST_RA:   st_q <= ST_RB;
				ST_RB: begin
					if (!it_q.op) st_q <= ST_R2;
					else if (out_free) st_q <= ST_IDLE;
				end
				ST_R2:   if (mul_done && ax_q == 2'(DIMENSIONS - 1)) st_q <= ST_C2;
				ST_C2:   if (mul_done) st_q <= ST_QCHK;
				ST_QCHK: begin
					if (r2_q == '0 || r2_q >= {2'b0, c2_q}) st_q <= ST_IDLE;
					else if ({6'b0, c2_q} >= {r2_q[79:0], 6'b0}) st_q <= ST_Q2;
					else st_q <= ST_QDIV;
				end
				ST_QDIV: if (div_done) st_q <= ST_Q2;
				ST_Q2:   if (mul_done) st_q <= ST_Q4;
				ST_Q4:   if (mul_done) st_q <= ST_Q6;
				ST_Q6:   if (mul_done) st_q <= ST_AX;
				ST_AX: begin
					if (ax_q == 2'(DIMENSIONS)) st_q <= ST_WB;
					else if (it_q.mag[ax_q] != '0) st_q <= ST_FM;
				end
				ST_FM:   if (mul_done) st_q <= ST_FG;
				ST_FG:   if (mul_done) st_q <= ST_MCHK;
				ST_MCHK: begin
					if (num_q >= {9'b0, r2_q[79:0], 39'b0}) st_q <= ST_ACC;
					else st_q <= ST_MDIV;
				end
				ST_MDIV: if (div_done) st_q <= ST_ACC;
				ST_ACC:  st_q <= ST_AX;
				ST_WB:   st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			it_q   <= q_head;
			addr_q <= AW'(q_head.idx);
		end
		unique case (st_q)
			ST_RB: begin
				acc_q  <= {rd_z_q, rd_y_q, rd_x_q};
				fl_q   <= rd_f_q;
				clip_q <= 1'b0;
				gs_q   <= 1'b0;
				ax_q   <= '0;
				r2_q   <= '0;
			end
			ST_R2: begin
				if (mul_done) begin
					r2_q <= r2_q + {2'b0, mul_p[79:0]};
					ax_q <= (ax_q == 2'(DIMENSIONS - 1)) ? '0 : ax_q + 1'b1;
				end
			end
			ST_C2: if (mul_done) c2_q <= mul_p[79:0];
			ST_QCHK: begin
				q_q    <= Q_CAP;
				clip_q <= 1'b1;
			end
			ST_QDIV: begin
				clip_q <= 1'b0;
				if (div_done) q_q <= div_quo[37:0];
			end
			ST_Q2: begin
				if (mul_done) begin
					q2_q <= mq_val;
					gs_q <= gs_q || mq_sat;
				end
			end
			ST_Q4: begin
				if (mul_done) begin
					g_q  <= mq_val;
					gs_q <= gs_q || mq_sat;
				end
			end
			ST_Q6: begin
				if (mul_done) begin
					g_q    <= (gs_q || mq_sat) ? '1 : mq_val - q2_q;
					clip_q <= clip_q || gs_q || mq_sat;
					ax_q   <= '0;
				end
			end
			ST_AX: if (ax_q != 2'(DIMENSIONS) && it_q.mag[ax_q] == '0) ax_q <= ax_q + 1'b1;
			ST_FM: if (mul_done) fm_q <= mul_p[63:0];
			ST_FG: if (mul_done) num_q <= mul_p;
			ST_MCHK: m_q <= M_CAP;
			ST_MDIV: if (div_done) m_q <= div_quo;
			ST_ACC: begin
				acc_q[ax_q] <= accs.val;
				clip_q      <= clip_q || accs.sat || (m_q == M_CAP && num_q >= {9'b0, r2_q[79:0], 39'b0});
				ax_q        <= ax_q + 1'b1;
			end
			default: ;
		endcase
		if (rsp_load) begin
			rsp_idx_q <= it_q.idx;
			if (it_q.oor) begin
				rsp_x_q <= '0;
				rsp_y_q <= '0;
				rsp_z_q <= '0;
				rsp_f_q <= 1'b0;
			end else begin
				rsp_x_q <= rd_x_q;
				if (DIMENSIONS == 3) begin
					rsp_y_q <= rd_y_q;
					rsp_z_q <= gravity_enable ? grav.val : rd_z_q;
				end else begin
					rsp_y_q <= gravity_enable ? grav.val : rd_y_q;
					rsp_z_q <= '0;
				end
				rsp_f_q <= rd_f_q || (gravity_enable && grav.sat);
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_index = rsp_idx_q;
	assign accel_x    = rsp_x_q;
	assign accel_y    = rsp_y_q;
	assign accel_z    = rsp_z_q;
	assign saturated  = rsp_f_q;

endmodule

// ----- hdl/boundary_repulsion_force_accumulator_top.sv -----
// Boundary repulsion force accumulator, top level: configuration registers,
// front end, queue and back end. Depends on brfa_pkg, brfa_front, brfa_queue, brfa_back.
// Read beat: popped in IDLE, stores read in RA, result register loaded in RB;
// pair beat: its time is set by the shared multi-cycle multiplier and the bit-serial divider.
// One beat is in the back end at a time; the two-entry queue takes beats meanwhile.
// After reset a clearing pass over all MAX_PARTICLES entries zeroes the stores before work starts.
module boundary_repulsion_force_accumulator_top #(
	parameter int unsigned MAX_PARTICLES = brfa_pkg::MAX_PARTICLES_DEF,
	parameter int unsigned DIMENSIONS    = brfa_pkg::DIMENSIONS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [brfa_pkg::CFGI_W-1:0]     wr_index,
	input  logic [brfa_pkg::CFG_W-1:0]      wr_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic                            op,
	input  logic [brfa_pkg::IDX_W-1:0]      particle_index,
	input  logic [brfa_pkg::TYPE_W-1:0]     type_first,
	input  logic [brfa_pkg::TYPE_W-1:0]     type_second,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_x,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_y,
	input  logic [brfa_pkg::POS_W-1:0]      first_pos_z,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_x,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_y,
	input  logic [brfa_pkg::POS_W-1:0]      second_pos_z,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic [brfa_pkg::IDX_W-1:0]      read_index,
	output logic [brfa_pkg::ACC_W-1:0]      accel_x,
	output logic [brfa_pkg::ACC_W-1:0]      accel_y,
	output logic [brfa_pkg::ACC_W-1:0]      accel_z,
	output logic                            saturated
);

	logic                            grav_en_q;
	logic [brfa_pkg::ACC_W-1:0]      grav_q;
	logic [brfa_pkg::CUT_W-1:0]      cutoff_q;
	logic [brfa_pkg::STR_W-1:0]      strength_q;
	logic                            q_full;
	logic                            q_push;
	logic                            q_pop;
	logic                            q_not_empty;
	brfa_pkg::item_t                 q_in;
	brfa_pkg::item_t                 q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_en_q  <= 1'b0;
			grav_q     <= brfa_pkg::GRAVITY_ACCEL_RST;
			cutoff_q   <= brfa_pkg::CUTOFF_DISTANCE_RST;
			strength_q <= brfa_pkg::FORCE_STRENGTH_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				brfa_pkg::REG_GRAVITY_ENABLE:  grav_en_q  <= wr_data[0];
				brfa_pkg::REG_GRAVITY_ACCEL:   grav_q     <= wr_data;
				brfa_pkg::REG_CUTOFF_DISTANCE: cutoff_q   <= wr_data[brfa_pkg::CUT_W-1:0];
				brfa_pkg::REG_FORCE_STRENGTH:  strength_q <= wr_data[brfa_pkg::STR_W-1:0];
				default: ;
			endcase
		end
	end

	brfa_front #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.DIMENSIONS    (DIMENSIONS)
	) u_front (
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.op             (op),
		.particle_index (particle_index),
		.type_first     (type_first),
		.type_second    (type_second),
		.first_pos_x    (first_pos_x),
		.first_pos_y    (first_pos_y),
		.first_pos_z    (first_pos_z),
		.second_pos_x   (second_pos_x),
		.second_pos_y   (second_pos_y),
		.second_pos_z   (second_pos_z),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (q_in)
	);

	brfa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	brfa_back #(
		.MAX_PARTICLES (MAX_PARTICLES),
		.DIMENSIONS    (DIMENSIONS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_not_empty     (q_not_empty),
		.q_head          (q_head),
		.q_pop           (q_pop),
		.gravity_enable  (grav_en_q),
		.gravity_accel   (grav_q),
		.cutoff_distance (cutoff_q),
		.force_strength  (strength_q),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.read_index      (read_index),
		.accel_x         (accel_x),
		.accel_y         (accel_y),
		.accel_z         (accel_z),
		.saturated       (saturated)
	);

endmodule
